// ----- sv/assert_macros.svh -----
// Assertion macros used by the port checker, sv/mb_checker.sv.
// Each wraps a concurrent assertion; CHECK_ALWAYS adds a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop on every rising clock edge outside of reset.
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks prop on every rising clock edge, reset cycles included.
`define CHECK_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/mb_pkg.sv -----
// Shared types and constants of the Mandelbrot escape-time pixel block.
// Used by all modules except mb_div and mb_fifo; no dependencies.
package mb_pkg;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [11:0] column_out;
    logic [11:0] row_out;
    logic [7:0]  iteration_count;
    logic [7:0]  shade;
  } result_t;

  typedef struct packed {
    logic [12:0] region_width;
    logic [12:0] region_height;
    logic [7:0]  iteration_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LIMIT  = 2'd2
  } cfg_index_t;

  localparam logic [12:0] RESET_WIDTH  = 13'd640;
  localparam logic [12:0] RESET_HEIGHT = 13'd480;
  localparam logic [7:0]  RESET_LIMIT  = 8'd48;

  typedef enum logic [2:0] {
    F_IDLE,
    F_STA,
    F_DIVA,
    F_STB,
    F_DIVB,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_UPD,
    B_SSTART,
    B_SWAIT,
    B_OUT
  } back_state_t;

endpackage

// ----- sv/mb_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// No dependencies; used by the front end and the back end.
module mb_div #(
  parameter int NW = 42,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quot[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DW'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[DW-1:0];
      end
      quot <= {quot[NW-2:0], fits};
    end
  end
endmodule

// ----- sv/mb_fifo.sv -----
// Small register queue between the coordinate front end and the iterating back end.
// No dependencies.
module mb_fifo #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    fill;

  assign full     = fill == CW'(DEPTH);
  assign empty    = fill == '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end
endmodule

// ----- sv/mb_front.sv -----
// Front end: maps each accepted pixel to the point c with one reused serial divider.
// Depends on mb_pkg and mb_div.
module mb_front #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mb_pkg::pixel_t           in_data,
  input  mb_pkg::cfg_t             cfg,
  input  logic                     q_full,
  output logic                     push,
  output logic [24+2*(FRAC_BITS+16)-1:0] push_data
);
  localparam int W  = FRAC_BITS + 16;
  localparam int NW = FRAC_BITS + 14;
  localparam int DW = $clog2(MAX_DIM + 1);

  mb_pkg::front_state_t state, state_next;

  logic [11:0]         col;
  logic [11:0]         row;
  logic signed [W-1:0] a;
  logic signed [W-1:0] b;
  logic [DW-1:0]       wc;
  logic [DW-1:0]       hc;
  logic [13:0]         col3;
  logic                div_start;
  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic                div_done;
  logic [NW-1:0]       div_quot;

  // Zero dimensions count as one, oversized ones as the largest supported.
  always_comb begin
    if (cfg.region_width == '0) begin
      wc = DW'(1);
    end else if (int'(cfg.region_width) > MAX_DIM) begin
      wc = DW'(MAX_DIM);
    end else begin
      wc = DW'(cfg.region_width);
    end
    if (cfg.region_height == '0) begin
      hc = DW'(1);
    end else if (int'(cfg.region_height) > MAX_DIM) begin
      hc = DW'(MAX_DIM);
    end else begin
      hc = DW'(cfg.region_height);
    end
  end

  assign col3 = {2'b00, col} + {1'b0, col, 1'b0};

  always_comb begin
    state_next = state;
    case (state)
      mb_pkg::F_IDLE: if (in_valid) state_next = mb_pkg::F_STA;
      mb_pkg::F_STA:  state_next = mb_pkg::F_DIVA;
      mb_pkg::F_DIVA: if (div_done) state_next = mb_pkg::F_STB;
      mb_pkg::F_STB:  state_next = mb_pkg::F_DIVB;
      mb_pkg::F_DIVB: if (div_done) state_next = mb_pkg::F_PUSH;
      mb_pkg::F_PUSH: if (!q_full) state_next = mb_pkg::F_IDLE;
      default: state_next = mb_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != mb_pkg::F_IDLE;
    div_start = 1'b0;
    div_num   = {col3, FRAC_BITS'(0)};
    div_den   = wc;
    push      = 1'b0;
    case (state)
      mb_pkg::F_STA: div_start = 1'b1;
      mb_pkg::F_STB: begin
        div_start = 1'b1;
        div_num   = {1'b0, row, 1'b0, FRAC_BITS'(0)};
        div_den   = hc;
      end
      mb_pkg::F_PUSH: push = !q_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mb_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mb_pkg::F_IDLE && in_valid) begin
      col <= in_data.column;
      row <= in_data.pixel_row;
    end
    if (state == mb_pkg::F_DIVA && div_done) begin
      a <= $signed(W'(div_quot)) - $signed(W'(2) << FRAC_BITS);
    end
    if (state == mb_pkg::F_DIVB && div_done) begin
      b <= $signed(W'(1) << FRAC_BITS) - $signed(W'(div_quot));
    end
  end

  assign push_data = {col, row, a, b};

  mb_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );
endmodule

// ----- sv/mb_back.sv -----
// Back end: iterates z = z*z + c (multiply, then update), then computes the shade.
// Depends on mb_pkg and mb_div.
module mb_back #(
  parameter int FRAC_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  logic [24+2*(FRAC_BITS+16)-1:0] q_data,
  output logic                     pop,
  input  mb_pkg::cfg_t             cfg,
  output logic                     out_valid,
  input  logic                     out_stall,
  output mb_pkg::result_t          out_data
);
  localparam int W  = FRAC_BITS + 16;
  localparam int MW = FRAC_BITS + 3;
  localparam int PW = 2 * MW;

  mb_pkg::back_state_t state, state_next;

  logic [11:0]          col;
  logic [11:0]          row;
  logic signed [W-1:0]  a;
  logic signed [W-1:0]  b;
  logic signed [W-1:0]  x;
  logic signed [W-1:0]  y;
  logic [7:0]           count;
  logic                 post;
  logic signed [PW-1:0] xx;
  logic signed [PW-1:0] yy;
  logic signed [PW-1:0] xy;
  logic [7:0]           shade;
  logic [7:0]           limit;
  logic [W-1:0]         magx;
  logic [W-1:0]         magy;
  logic                 big;
  logic [PW:0]          sum;
  logic                 esc;
  logic                 at_limit;
  logic signed [W-1:0]  nx;
  logic signed [W-1:0]  ny;
  logic signed [MW-1:0] xs;
  logic signed [MW-1:0] ys;
  logic                 div_start;
  logic                 div_done;
  logic [15:0]          div_quot;

  assign limit = (cfg.iteration_limit == '0) ? 8'd1 : cfg.iteration_limit;

  assign magx = x[W-1] ? W'(-x) : W'(x);
  assign magy = y[W-1] ? W'(-y) : W'(y);
  assign big  = post && ((magx > (W'(2) << FRAC_BITS)) || (magy > (W'(2) << FRAC_BITS)));

  // Operands are only meaningful once the magnitude test has passed.
  assign xs = x[MW-1:0];
  assign ys = y[MW-1:0];

  assign sum      = {1'b0, xx} + {1'b0, yy};
  assign esc      = post && (sum > ((PW+1)'(1) << (2 * FRAC_BITS + 2)));
  assign at_limit = post && ({1'b0, count} + 9'd1 == {1'b0, limit});
  assign nx = W'(xx >>> FRAC_BITS) - W'(yy >>> FRAC_BITS) + a;
  assign ny = W'(xy >>> (FRAC_BITS - 1)) + b;

  always_comb begin
    state_next = state;
    case (state)
      mb_pkg::B_IDLE:   if (!q_empty) state_next = mb_pkg::B_MUL;
      mb_pkg::B_MUL:    state_next = big ? mb_pkg::B_SSTART : mb_pkg::B_UPD;
      mb_pkg::B_UPD:    state_next = (esc || at_limit) ? mb_pkg::B_SSTART : mb_pkg::B_MUL;
      mb_pkg::B_SSTART: state_next = mb_pkg::B_SWAIT;
      mb_pkg::B_SWAIT:  if (div_done) state_next = mb_pkg::B_OUT;
      mb_pkg::B_OUT:    if (!out_stall) state_next = mb_pkg::B_IDLE;
      default:          state_next = mb_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    out_valid = 1'b0;
    case (state)
      mb_pkg::B_IDLE:   pop = !q_empty;
      mb_pkg::B_SSTART: div_start = 1'b1;
      mb_pkg::B_OUT:    out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mb_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mb_pkg::B_IDLE: begin
        if (!q_empty) begin
          {col, row, a, b} <= q_data;
          x     <= '0;
          y     <= '0;
          count <= '0;
          post  <= 1'b0;
        end
      end
      mb_pkg::B_MUL: begin
        xx <= xs * xs;
        yy <= ys * ys;
        xy <= xs * ys;
      end
      mb_pkg::B_UPD: begin
        // A non-escaping update is counted when its own check passes.
        if (!esc) begin
          count <= count + 8'(post);
          if (!at_limit) begin
            x    <= nx;
            y    <= ny;
            post <= 1'b1;
          end
        end
      end
      mb_pkg::B_SWAIT: begin
        if (div_done) begin
          shade <= div_quot[7:0];
        end
      end
      default: ;
    endcase
  end

  assign out_data.column_out      = col;
  assign out_data.row_out         = row;
  assign out_data.iteration_count = count;
  assign out_data.shade           = shade;

  mb_div #(.NW(16), .DW(8)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({count, 8'd0} - {8'd0, count}),
    .den   (limit),
    .done  (div_done),
    .quot  (div_quot)
  );
endmodule

// ----- sv/mandelbrot_escape_time_pixel.sv -----
// Top level of the Mandelbrot escape-time pixel block.
// Depends on mb_pkg, mb_front, mb_fifo and mb_back.
//
// Usage:
//   in_valid/in_stall/in_data carry pixel requests (column, row). A request
//   is taken at a clock edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_data carry one result per request, in order:
//   the pixel position, the iteration count and the grey shade.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the region width (0),
//   region height (1) and iteration limit (2); cfg_ready is always high.
//   Write the configuration only while no request is in flight.
// Flow:
//   The front end maps a pixel to c with one serial divider, one quotient
//   bit per cycle, first for the real part and then for the imaginary part.
//   The back end runs each complex iteration as a multiply step, then an
//   update and escape test, and then runs the shade divider and the output.
//   A two-entry queue between them lets the mapping of the next pixel run
//   while the current one iterates; the sustained rate is set by the slower
//   of the two.
// Reset (synchronous, rst high) empties the queue, idles both ends and
// restores width 640, height 480 and limit 48. While out_stall is high the
// result is held and the back end waits; the front end keeps accepting
// until the queue is full and it holds one mapped pixel of its own.
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  mb_pkg::pixel_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mb_pkg::result_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [12:0]     cfg_data
);
  localparam int QW = 24 + 2 * (FRAC_BITS + 16);

  mb_pkg::cfg_t cfg;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_width    <= mb_pkg::RESET_WIDTH;
      cfg.region_height   <= mb_pkg::RESET_HEIGHT;
      cfg.iteration_limit <= mb_pkg::RESET_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mb_pkg::REG_WIDTH:  cfg.region_width    <= cfg_data;
        mb_pkg::REG_HEIGHT: cfg.region_height   <= cfg_data;
        mb_pkg::REG_LIMIT:  cfg.iteration_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mb_front #(.FRAC_BITS(FRAC_BITS), .MAX_DIM(MAX_DIM)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  mb_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  mb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .pop       (q_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule

// ----- sv/mb_checker.sv -----
// Port-level checks for the Mandelbrot escape-time pixel block, bound to the top.
// Depends on mb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mb_port_checks (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input mb_pkg::result_t out_data
);
  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Requests taken but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
    end
  end

  `CHECK_ALWAYS(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `CHECK_ANY(a_reset_idle, clk, $past(rst) |-> !out_valid, "result shown right after reset")
  `CHECK_ALWAYS(a_no_orphan, clk, rst, out_valid |-> pending != 3'd0, "result without a request")
  `CHECK_ALWAYS(a_bounded, clk, rst, pending <= 3'd4, "more requests in flight than storage")
endmodule

bind mandelbrot_escape_time_pixel mb_port_checks u_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- tb/sv/mb_checker.sv -----
`timescale 1ns / 100ps
// Checker for the Mandelbrot escape-time pixel block: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on mb_pkg.
module mb_checker #(
  parameter int FRAC_BITS = 28,
  parameter int MAX_DIM   = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  mb_pkg::pixel_t  in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  mb_pkg::result_t out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [12:0]     cfg_data,
  output int              errors,
  output int              pending
);
  logic [12:0]     width_q;
  logic [12:0]     height_q;
  logic [7:0]      limit_q;
  mb_pkg::result_t expected_q[$];

  assign pending = expected_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic signed [63:0] fix_mul(input logic signed [63:0] p,
                                                 input logic signed [63:0] q,
                                                 input int sh);
    logic signed [127:0] full;
    full = 128'(p) * 128'(q);
    return 64'(full >>> sh);
  endfunction

  function automatic mb_pkg::result_t escape_time(input mb_pkg::pixel_t px);
    mb_pkg::result_t r;
    logic [63:0] w, h, lim;
    logic signed [63:0] one, a, b, x, y, nx, ny, two;
    logic signed [127:0] mag2;
    logic [31:0] cnt;
    bit out;
    w = (width_q == 0) ? 1 : (width_q > MAX_DIM) ? MAX_DIM : width_q;
    h = (height_q == 0) ? 1 : (height_q > MAX_DIM) ? MAX_DIM : height_q;
    lim = (limit_q == 0) ? 1 : limit_q;
    one = 64'sd1 <<< FRAC_BITS;
    two = 2 * one;
    a = $signed((64'(3 * px.column) << FRAC_BITS) / w) - two;
    b = one - $signed((64'(2 * px.pixel_row) << FRAC_BITS) / h);
    x = 0;
    y = 0;
    cnt = 0;
    // The count stops at the limit, or before the iteration that escapes.
    forever begin
      nx = fix_mul(x, x, FRAC_BITS) - fix_mul(y, y, FRAC_BITS) + a;
      ny = fix_mul(x, y, FRAC_BITS - 1) + b;
      x = nx;
      y = ny;
      out = (x > two) || (x < -two) || (y > two) || (y < -two);
      if (!out) begin
        mag2 = 128'(x) * 128'(x) + 128'(y) * 128'(y);
        out = mag2 > (128'sd1 <<< (2 * FRAC_BITS + 2));
      end
      if (out) break;
      cnt++;
      if (cnt >= lim) break;
    end
    r.column_out = px.column;
    r.row_out = px.pixel_row;
    r.iteration_count = cnt[7:0];
    r.shade = 8'((cnt * 255) / lim);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_q <= mb_pkg::RESET_WIDTH;
      height_q <= mb_pkg::RESET_HEIGHT;
      limit_q <= mb_pkg::RESET_LIMIT;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (mb_pkg::cfg_index_t'(cfg_index))
          mb_pkg::REG_WIDTH: begin
            width_q <= cfg_data;
          end
          mb_pkg::REG_HEIGHT: begin
            height_q <= cfg_data;
          end
          mb_pkg::REG_LIMIT: begin
            limit_q <= cfg_data[7:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(escape_time(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", out_data.column_out, 0);
        end else begin
          mb_pkg::result_t e;
          e = expected_q.pop_front();
          if (out_data.column_out !== e.column_out)
            report("column", out_data.column_out, e.column_out);
          if (out_data.row_out !== e.row_out) report("row", out_data.row_out, e.row_out);
          if (out_data.iteration_count !== e.iteration_count)
            report("count", out_data.iteration_count, e.iteration_count);
          if (out_data.shade !== e.shade) report("shade", out_data.shade, e.shade);
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the Mandelbrot escape-time pixel block: drives pixel
// requests, register writes and output stalls. Depends on mb_pkg, mb_checker.
module tb;
  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  mb_pkg::pixel_t  in_data;
  logic            out_valid;
  logic            out_stall;
  mb_pkg::result_t out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [1:0]      cfg_index;
  logic [12:0]     cfg_data;
  int              errors;
  int              pending;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              hold_cycles;
  logic            hold_go;
  logic            hold_done;

  mandelbrot_escape_time_pixel dut (.*);
  mb_checker chk (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #400ms;
    $display("FAIL");
    $finish;
  end

  // Receiver stall, with one long hold-off counted here once requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cycles <= 3000;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // The request stays valid after it is taken; the next call or a register
  // write decides what follows.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{column: col, pixel_row: row};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input mb_pkg::cfg_index_t idx, input logic [12:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_region(input logic [12:0] w, input logic [12:0] h, input logic [7:0] lim);
    write_reg(mb_pkg::REG_WIDTH, w);
    write_reg(mb_pkg::REG_HEIGHT, h);
    write_reg(mb_pkg::REG_LIMIT, {5'd0, lim});
  endtask

  // Mostly in-window pixels, some anywhere in the field range.
  task automatic random_pixels(input int n, input logic [12:0] w, input logic [12:0] h);
    logic [11:0] c, r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        c = 12'($urandom);
        r = 12'($urandom);
      end else begin
        c = 12'($urandom_range((w == 0 ? 1 : w) - 1));
        r = 12'($urandom_range((h == 0 ? 1 : h) - 1));
      end
      send_pixel(c, r);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_go = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, center, out-of-region pixels at reset values.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd426, 12'd240);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    // Zero sizes and limit are treated as one.
    set_region(13'd0, 13'd0, 8'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    // Sizes above the maximum are clamped.
    set_region(13'h1fff, 13'h1fff, 8'd255);
    send_pixel(12'd2730, 12'd2048);
    send_pixel(12'd2048, 12'd2048);
    send_pixel(12'd4095, 12'd4095);
    set_region(13'd4096, 13'd4096, 8'd1);
    send_pixel(12'd2730, 12'd2048);
    send_pixel(12'd0, 12'd0);

    // Long hold-off while requests keep coming, so the queue fills.
    set_region(13'd64, 13'd48, 8'd48);
    hold_go <= 1'b1;
    random_pixels(8, 13'd64, 13'd48);

    send_idle_pct = 37;
    recv_idle_pct = 75;
    set_region(13'd96, 13'd64, 8'd32);
    random_pixels(500, 13'd96, 13'd64);

    send_idle_pct = 75;
    recv_idle_pct = 37;
    set_region(13'd1, 13'd1, 8'd255);
    random_pixels(100, 13'd1, 13'd1);
    set_region(13'd640, 13'd480, 8'd16);
    random_pixels(400, 13'd640, 13'd480);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_region(13'd4096, 13'd4096, 8'd8);
    random_pixels(400, 13'd4096, 13'd4096);
    set_region(13'd33, 13'd17, 8'd100);
    random_pixels(480, 13'd33, 13'd17);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/mb_pkg.sv
sv/mb_div.sv
sv/mb_fifo.sv
sv/mb_front.sv
sv/mb_back.sv
sv/mandelbrot_escape_time_pixel.sv
sv/mb_checker.sv
tb/sv/mb_checker.sv
tb/sv/tb.sv
